// ----- hw/rtl/battery_voltage_scale_average_unit_macros.svh -----
// ---------------------------------------------------------------------------
// battery voltage scale/average unit assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_SCALE_AVERAGE_UNIT_MACROS_SVH
`define BATTERY_VOLTAGE_SCALE_AVERAGE_UNIT_MACROS_SVH

// same-cycle implication
`define BVSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BVSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// plain invariant
`define BVSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bvsa_pkg.sv -----
// ---------------------------------------------------------------------------
// bvsa_pkg
// types, constants and register codes of the battery voltage scale/average unit
// ---------------------------------------------------------------------------
package bvsa_pkg;

  // ring depth, power of two
  localparam int HIST_DEPTH = 16;
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int VOLT_W     = 16;
  localparam int SUM_W      = VOLT_W + HIST_IDX_W;
  localparam int CODE_W     = 12;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // fixed point scale, 13590 / 2^24 ~ 0.00081
  localparam logic signed [14:0] LSB_SCALE = 15'sd13590;
  localparam int LSB_SHIFT = 24;
  localparam int PROD1_W   = CODE_W + 1 + CFG_W;
  localparam int PROD2_W   = PROD1_W + 14;
  localparam int SHIFT_W   = PROD2_W - LSB_SHIFT;
  localparam int SUMV_W    = SHIFT_W + 2;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd512;

  typedef struct packed {
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] offset;
    logic [CFG_W-1:0] threshold;
  } cfg_regs_t;

  typedef struct packed {
    logic              valid;
    logic [VOLT_W-1:0] volt;
  } q_word_t;

endpackage

// ----- hw/rtl/bvsa_in_if.sv -----
// ---------------------------------------------------------------------------
// bvsa_in_if
// input channel: one raw adc code per transfer
// ---------------------------------------------------------------------------
interface bvsa_in_if;
  logic                        valid;
  logic                        ready;
  logic [bvsa_pkg::CODE_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

// ----- hw/rtl/bvsa_out_if.sv -----
// ---------------------------------------------------------------------------
// bvsa_out_if
// result channel: scaled voltage and ring mean per transfer
// ---------------------------------------------------------------------------
interface bvsa_out_if;
  logic                        valid;
  logic                        ready;
  logic [bvsa_pkg::VOLT_W-1:0] last_voltage;
  logic [bvsa_pkg::VOLT_W-1:0] average_voltage;
  logic                        average_ready;

  modport source (output valid, output last_voltage, output average_voltage,
                  output average_ready, input ready);
  modport sink (input valid, input last_voltage, input average_voltage,
                input average_ready, output ready);
endinterface

// ----- hw/rtl/bvsa_cfg_if.sv -----
// ---------------------------------------------------------------------------
// bvsa_cfg_if
// configuration write channel: register index and data per transfer
// ---------------------------------------------------------------------------
interface bvsa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bvsa_pkg::CFG_IDX_W-1:0] index;
  logic [bvsa_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/battery_voltage_scale_average_unit.sv -----
// ---------------------------------------------------------------------------
// battery_voltage_scale_average_unit
// scales adc codes to battery voltage and keeps a 16-entry moving average
// ---------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    adc_code[11:0]
//  out_ch    out  valid/ready    last_voltage[15:0] average_voltage[15:0] average_ready
//  cfg_ch    in   valid/ready    index[1:0] data[15:0], ready always high
//
//  one item per cycle sustained while out_ready stays high; an in transfer reaches
//  out valid through two multiply stages, the queue and the output register
//  synchronous reset clears ring, sum, pointers, valid flags, gain and offset, threshold to 512
//  out_ready low fills the output register, then the 4-entry queue, then the
//  multiply stages, after which in_ready drops
// ---------------------------------------------------------------------------
module battery_voltage_scale_average_unit (
  input  logic        clk,
  input  logic        rst_n,
  bvsa_in_if.sink     in_ch,
  bvsa_out_if.source  out_ch,
  bvsa_cfg_if.sink    cfg_ch
);

  bvsa_pkg::cfg_regs_t cfg_r;
  bvsa_pkg::q_word_t   push;
  bvsa_pkg::q_word_t   head;
  logic                q_full;
  logic                pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= '0;
      cfg_r.offset    <= '0;
      cfg_r.threshold <= bvsa_pkg::THRESHOLD_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bvsa_pkg::CFG_GAIN:      cfg_r.gain      <= cfg_ch.data;
        bvsa_pkg::CFG_OFFSET:    cfg_r.offset    <= cfg_ch.data;
        bvsa_pkg::CFG_THRESHOLD: cfg_r.threshold <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  bvsa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .push   (push)
  );

  bvsa_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  bvsa_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- hw/rtl/bvsa_front.sv -----
// ---------------------------------------------------------------------------
// bvsa_front
// accepts adc codes and scales them to clamped voltages in two multiply stages
// ---------------------------------------------------------------------------
module bvsa_front (
  input  logic                clk,
  input  logic                rst_n,
  bvsa_in_if.sink             in_ch,
  input  bvsa_pkg::cfg_regs_t cfg,
  input  logic                q_full,
  output bvsa_pkg::q_word_t   push
);

  logic                                  s1_v_r;
  logic signed [bvsa_pkg::PROD1_W-1:0]   s1_m_r;
  logic                                  s2_v_r;
  logic signed [bvsa_pkg::PROD2_W-1:0]   s2_p_r;

  logic                                  adv1;
  logic                                  adv2;
  logic signed [bvsa_pkg::PROD1_W-1:0]   m1;
  logic signed [bvsa_pkg::PROD2_W-1:0]   m2;
  logic signed [bvsa_pkg::SHIFT_W-1:0]   sh;
  logic signed [bvsa_pkg::SUMV_W-1:0]    v;

  assign adv2        = !s2_v_r || !q_full;
  assign adv1        = !s1_v_r || adv2;
  assign in_ch.ready = adv1;

  always_comb begin
    m1 = $signed({1'b0, in_ch.adc_code}) * $signed(cfg.gain);
    m2 = s1_m_r * bvsa_pkg::LSB_SCALE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_ch.valid;
      if (adv2) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1_m_r <= m1;
    if (adv2) s2_p_r <= m2;
  end

  // floor shift, offset and clamp to 0..65535
  always_comb begin
    sh = s2_p_r[bvsa_pkg::PROD2_W-1:bvsa_pkg::LSB_SHIFT];
    v  = bvsa_pkg::SUMV_W'(sh) + bvsa_pkg::SUMV_W'($signed(cfg.offset));
    push.valid = s2_v_r;
    if (v[bvsa_pkg::SUMV_W-1]) begin
      push.volt = '0;
    end else if (v[bvsa_pkg::SUMV_W-2:bvsa_pkg::VOLT_W] != '0) begin
      push.volt = '1;
    end else begin
      push.volt = v[bvsa_pkg::VOLT_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/bvsa_queue.sv -----
// ---------------------------------------------------------------------------
// bvsa_queue
// small fifo of scaled voltages between front and back
// ---------------------------------------------------------------------------
module bvsa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  bvsa_pkg::q_word_t push,
  output logic              full,
  output bvsa_pkg::q_word_t head,
  input  logic              pop
);

  logic [bvsa_pkg::VOLT_W-1:0] mem_r [bvsa_pkg::QDEPTH];
  logic [bvsa_pkg::QPTR_W-1:0] wr_r;
  logic [bvsa_pkg::QPTR_W-1:0] rd_r;
  logic [bvsa_pkg::QCNT_W-1:0] cnt_r;
  logic [bvsa_pkg::QCNT_W-1:0] cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (cnt_r == bvsa_pkg::QCNT_W'(bvsa_pkg::QDEPTH));
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.volt  = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push.volt;
  end

endmodule

// ----- hw/rtl/bvsa_back.sv -----
// ---------------------------------------------------------------------------
// bvsa_back
// ring update, running sum, threshold check and output register
// ---------------------------------------------------------------------------
module bvsa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bvsa_pkg::cfg_regs_t cfg,
  input  bvsa_pkg::q_word_t   head,
  output logic                pop,
  bvsa_out_if.source          out_ch
);

  `include "battery_voltage_scale_average_unit_macros.svh"

  logic [bvsa_pkg::VOLT_W-1:0]     hist_r [bvsa_pkg::HIST_DEPTH];
  logic [bvsa_pkg::HIST_IDX_W-1:0] wp_r;
  logic [bvsa_pkg::HIST_IDX_W-1:0] wp_nxt;
  logic [bvsa_pkg::SUM_W-1:0]      sum_r;
  logic [bvsa_pkg::SUM_W-1:0]      sum_nxt;
  logic                            out_valid_r;
  logic [bvsa_pkg::VOLT_W-1:0]     last_r;
  logic [bvsa_pkg::VOLT_W-1:0]     avg_r;
  logic                            avg_ok_r;

  logic                            all_ok;
  logic [bvsa_pkg::VOLT_W-1:0]     ent;

  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    sum_nxt = sum_r - bvsa_pkg::SUM_W'(hist_r[wp_r]) + bvsa_pkg::SUM_W'(head.volt);
    wp_nxt  = (wp_r == bvsa_pkg::HIST_IDX_W'(bvsa_pkg::HIST_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    all_ok  = 1'b1;
    ent     = '0;
    for (int i = 0; i < bvsa_pkg::HIST_DEPTH; i++) begin
      ent = (bvsa_pkg::HIST_IDX_W'(i) == wp_r) ? head.volt : hist_r[i];
      if (ent < cfg.threshold) all_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bvsa_pkg::HIST_DEPTH; i++) hist_r[i] <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        hist_r[wp_r] <= head.volt;
        wp_r         <= wp_nxt;
        sum_r        <= sum_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      last_r   <= head.volt;
      avg_r    <= all_ok ? sum_nxt[bvsa_pkg::SUM_W-1:bvsa_pkg::HIST_IDX_W] : '0;
      avg_ok_r <= all_ok;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.last_voltage    = last_r;
  assign out_ch.average_voltage = avg_r;
  assign out_ch.average_ready   = avg_ok_r;

  `BVSA_ASSERT_IMPL(a_pop_has_data, pop, head.valid, "pop from empty queue")
  `BVSA_ASSERT_NEXT(a_pop_fills_out, pop, out_valid_r, "popped item not presented")
  `BVSA_ASSERT_IMPL(a_not_ready_zero, out_valid_r && !avg_ok_r, avg_r == '0,
                    "average nonzero while not ready")

endmodule

// ----- tb/sv/battery_voltage_scale_average_unit_tb.sv -----
// ---------------------------------------------------------------------------
// battery_voltage_scale_average_unit_tb
// A self-checking bench for the scale/average unit. Codes go in as directed
// cases, then as random bursts, and the result channel stalls on a pattern
// of its own. A scoreboard keeps its own copy of the ring and the registers,
// and works out the expected voltage, mean and ready flag for each code that
// goes in. Every result is checked against the oldest expectation. Registers
// are rewritten between phases, once the unit has drained.
// ---------------------------------------------------------------------------
module battery_voltage_scale_average_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bvsa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint VOLT_FULL  = (longint'(1) << bvsa_pkg::VOLT_W) - 1;
  localparam int     TOTAL_ITEMS = 550;
  localparam int     LATENCY     = 4;
  localparam int     STALL_LIMIT = 1000;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    logic [bvsa_pkg::VOLT_W-1:0] last_voltage;
    logic [bvsa_pkg::VOLT_W-1:0] average_voltage;
    logic                        average_ready;
  } volt_result_t;

  class voltage_scoreboard;
    logic signed [bvsa_pkg::CFG_W-1:0] gain;
    logic signed [bvsa_pkg::CFG_W-1:0] offset;
    logic [bvsa_pkg::CFG_W-1:0]        threshold;
    logic [bvsa_pkg::VOLT_W-1:0]       ring [bvsa_pkg::HIST_DEPTH];
    logic [bvsa_pkg::HIST_IDX_W-1:0]   wr_pos;
    volt_result_t                      expected_q[$];
    int unsigned                       mismatches;
    int unsigned                       results_seen;
    int unsigned                       reg_writes;
    int unsigned                       full_avg;
    int unsigned                       clamp_lo;
    int unsigned                       clamp_hi;

    function new();
      gain = '0;
      offset = '0;
      threshold = bvsa_pkg::THRESHOLD_RESET;
      wr_pos = '0;
      foreach (ring[i]) ring[i] = '0;
      mismatches = 0;
      results_seen = 0;
      reg_writes = 0;
      full_avg = 0;
      clamp_lo = 0;
      clamp_hi = 0;
    endfunction

    function void write_reg(logic [bvsa_pkg::CFG_IDX_W-1:0] idx,
                            logic [bvsa_pkg::CFG_W-1:0] data);
      reg_writes++;
      case (idx)
        bvsa_pkg::CFG_GAIN: begin
          gain = data;
        end
        bvsa_pkg::CFG_OFFSET: begin
          offset = data;
        end
        bvsa_pkg::CFG_THRESHOLD: begin
          threshold = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void note_input(logic [bvsa_pkg::CODE_W-1:0] code);
      longint       product;
      longint       volt;
      longint       total;
      logic         all_valid;
      volt_result_t r;
      product = longint'(code) * longint'(gain) * longint'(bvsa_pkg::LSB_SCALE);
      volt = (product >>> bvsa_pkg::LSB_SHIFT) + longint'(offset);
      if (volt < 0) begin
        volt = 0;
        clamp_lo++;
      end else if (volt > VOLT_FULL) begin
        volt = VOLT_FULL;
        clamp_hi++;
      end
      r.last_voltage = volt[bvsa_pkg::VOLT_W-1:0];
      ring[wr_pos] = r.last_voltage;
      wr_pos = wr_pos + 1'b1;
      total = 0;
      all_valid = 1'b1;
      foreach (ring[i]) begin
        if (ring[i] < threshold) all_valid = 1'b0;
        total += ring[i];
      end
      total = total / bvsa_pkg::HIST_DEPTH;
      r.average_ready = all_valid;
      r.average_voltage = all_valid ? total[bvsa_pkg::VOLT_W-1:0] : '0;
      if (all_valid) full_avg++;
      expected_q.push_back(r);
    endfunction

    function void check_result(volt_result_t got);
      volt_result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing outstanding: last %0d avg %0d ready %0b",
                   $realtime, got.last_voltage, got.average_voltage, got.average_ready);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.last_voltage !== exp_r.last_voltage ||
          got.average_voltage !== exp_r.average_voltage ||
          got.average_ready !== exp_r.average_ready) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result %0d: last %0d/%0d avg %0d/%0d ready %0b/%0b (exp/act)",
                   $realtime, results_seen, exp_r.last_voltage, got.last_voltage,
                   exp_r.average_voltage, got.average_voltage,
                   exp_r.average_ready, got.average_ready);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit clean();
      return mismatches == 0 && expected_q.size() == 0;
    endfunction

    function void report();
      if (expected_q.size() != 0)
        $display("%0d expected results never came out", expected_q.size());
      $display("%0d results over %0d register writes, %0d mismatches",
               results_seen, reg_writes, mismatches);
      $display("%0d with a full valid ring, %0d clamped to zero, %0d clamped to full scale",
               full_avg, clamp_lo, clamp_hi);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   items_sent;
  voltage_scoreboard sb = new();

  bvsa_in_if  in_ch();
  bvsa_out_if out_ch();
  bvsa_cfg_if cfg_ch();

  battery_voltage_scale_average_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.adc_code);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.last_voltage, out_ch.average_voltage,
                          out_ch.average_ready});
    end
  end

  // result channel stall pattern
  initial begin : result_stalls
    int   seg_left;
    int   mode;
    int   hold;
    logic level;
    out_ch.ready <= 1'b0;
    seg_left = 0;
    mode = 0;
    hold = 0;
    level = 1'b1;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 160);
        mode = $urandom_range(0, 3);
      end
      seg_left--;
      case (mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (hold == 0) begin
            hold = $urandom_range(1, 20);
            level = ~level;
          end
          hold--;
          out_ch.ready <= level;
        end
      endcase
    end
  end

  initial begin : watchdog
    int stall_count;
    stall_count = 0;
    while (stall_count < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_count = 0;
      else
        stall_count++;
    end
    $display("no transfer for %0d cycles", STALL_LIMIT);
    $display("battery_voltage_scale_average_unit verification failed");
    $finish;
  end

  task automatic send_code(input logic [bvsa_pkg::CODE_W-1:0] code);
    in_ch.valid <= 1'b1;
    in_ch.adc_code <= code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [bvsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bvsa_pkg::CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_phase();
    logic [2:0]                  reg_mask;
    logic [bvsa_pkg::CFG_W-1:0]  data;
    logic [bvsa_pkg::CODE_W-1:0] code;
    int                          n_items;
    int                          burst;
    int                          gap;
    int                          style;
    int                          base;
    int                          c;
    drain_results();
    reg_mask = 3'($urandom_range(1, 7));
    if (reg_mask[0]) begin
      case ($urandom_range(0, 5))
        0: data = 16'h8000;
        1: data = 16'h7fff;
        2: data = '0;
        3: data = 16'($urandom);
        default: data = 16'($urandom_range(1000, 30000));
      endcase
      write_reg(bvsa_pkg::CFG_GAIN, data);
    end
    if (reg_mask[1]) begin
      case ($urandom_range(0, 5))
        0: data = 16'h8000;
        1: data = 16'h7fff;
        2: data = '0;
        3: data = 16'($urandom);
        default: data = 16'(int'($urandom_range(0, 4000)) - 2000);
      endcase
      write_reg(bvsa_pkg::CFG_OFFSET, data);
    end
    if (reg_mask[2]) begin
      case ($urandom_range(0, 5))
        0: data = '0;
        1: data = 16'hffff;
        2: data = bvsa_pkg::THRESHOLD_RESET;
        3: data = 16'($urandom);
        default: data = 16'($urandom_range(0, 3000));
      endcase
      write_reg(bvsa_pkg::CFG_THRESHOLD, data);
    end
    if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 16'($urandom));

    n_items = $urandom_range(30, 70);
    style = $urandom_range(0, 2);
    base = $urandom_range(1024, 4095);
    while (n_items > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > n_items) burst = n_items;
      n_items -= burst;
      for (int k = 0; k < burst; k++) begin
        c = $urandom_range(0, 9);
        if (c == 0) begin
          case ($urandom_range(0, 3))
            0: code = '0;
            1: code = 12'hfff;
            2: code = 12'h800;
            default: code = 12'h7ff;
          endcase
        end else if (style == 0 || c < 3) begin
          code = 12'($urandom_range(0, 4095));
        end else begin
          c = base + int'($urandom_range(0, 255)) - 128;
          if (c > 4095) c = 4095;
          code = c[bvsa_pkg::CODE_W-1:0];
        end
        send_code(code);
      end
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        7: gap = $urandom_range(13, 30);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    items_sent = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.adc_code <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers, ring still all zeros
    send_code(12'h000);
    send_code(12'hfff);

    // most negative gain clamps to zero, zero threshold keeps mean valid
    drain_results();
    write_reg(bvsa_pkg::CFG_GAIN, 16'h8000);
    write_reg(bvsa_pkg::CFG_OFFSET, 16'h0000);
    write_reg(bvsa_pkg::CFG_THRESHOLD, 16'h0000);
    send_code(12'hfff);
    send_code(12'h555);
    send_code(12'haaa);

    // most negative offset, write to the unused index is dropped
    drain_results();
    write_reg(bvsa_pkg::CFG_GAIN, 16'h0000);
    write_reg(bvsa_pkg::CFG_OFFSET, 16'h8000);
    write_reg(CFG_UNUSED, 16'hffff);
    send_code(12'h800);
    send_code(12'h7ff);

    // full scale overflow, full threshold, ring fills and wraps
    drain_results();
    write_reg(bvsa_pkg::CFG_GAIN, 16'h7fff);
    write_reg(bvsa_pkg::CFG_OFFSET, 16'h7fff);
    write_reg(bvsa_pkg::CFG_THRESHOLD, 16'hffff);
    repeat (bvsa_pkg::HIST_DEPTH) send_code(12'($urandom_range(2048, 4095)));

    while (items_sent < TOTAL_ITEMS) random_phase();

    drain_results();
    repeat (5 * LATENCY) @(posedge clk);
    sb.report();
    if (sb.clean())
      $display("battery_voltage_scale_average_unit verification clean");
    else
      $display("battery_voltage_scale_average_unit verification failed");
    $finish;
  end

endmodule
